[rtl/thc_pkg.sv]
`timescale 1ns / 1ps
// Package for the heat/cool thermostat: mode codes, register indexes,
// configuration and state structs. No dependencies.
package thc_pkg;

  localparam int unsigned HYST_FACTOR_Q8 = 128;

  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned HYST_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THRESH_W = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEAT = 2'd1,
    MODE_COOL = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_HYST_LOW      = 3'd1,
    REG_HYST_HIGH     = 3'd2,
    REG_MIN_HEAT_ON   = 3'd3,
    REG_MIN_HEAT_OFF  = 3'd4,
    REG_MIN_COOL_ON   = 3'd5,
    REG_MIN_COOL_OFF  = 3'd6,
    REG_ENABLE_MASK   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic [HYST_W-1:0]        hyst_below;
    logic [HYST_W-1:0]        hyst_above;
    logic [TIME_W-1:0]        min_heater_on_ms;
    logic [TIME_W-1:0]        min_heater_off_ms;
    logic [TIME_W-1:0]        min_cooler_on_ms;
    logic [TIME_W-1:0]        min_cooler_off_ms;
    logic [1:0]               enable_mask;
  } thc_cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] heater_toggle_time;
    logic [TIME_W-1:0] cooler_toggle_time;
  } thc_state_t;

endpackage

[rtl/thc_in_if.sv]
`timescale 1ns / 1ps
// Sample channel: one temperature word per handshake.
// Depends on nothing.
interface thc_in_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temp_sample;
  logic               sensor_lost;
  logic [31:0]        now_ms;

  modport source (output valid, temp_sample, sensor_lost, now_ms, input ready);
  modport sink   (input valid, temp_sample, sensor_lost, now_ms, output ready);
endinterface

[rtl/thc_out_if.sv]
`timescale 1ns / 1ps
// Result channel: mode and drive levels, one word per handshake.
// Depends on nothing.
interface thc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       heater_drive;
  logic       cooler_drive;

  modport source (output valid, mode, heater_drive, cooler_drive, input ready);
  modport sink   (input valid, mode, heater_drive, cooler_drive, output ready);
endinterface

[rtl/thc_cfg_if.sv]
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on nothing.
interface thc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/thc_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file of the thermostat.
// Depends on thc_pkg and thc_cfg_if.
module thc_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  thc_cfg_if.sink         cfg_if,
  output thc_pkg::thc_cfg_t cfg
);
  import thc_pkg::*;

  thc_cfg_t cfg_r;
  thc_cfg_t cfg_nxt;
  logic     wr_en;

  assign cfg_if.ready = 1'b1;
  assign wr_en = cfg_if.valid && cfg_if.ready;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_SETPOINT:     cfg_nxt.setpoint          = signed'(cfg_if.data[TEMP_W-1:0]);
        REG_HYST_LOW:     cfg_nxt.hyst_below        = cfg_if.data[HYST_W-1:0];
        REG_HYST_HIGH:    cfg_nxt.hyst_above        = cfg_if.data[HYST_W-1:0];
        REG_MIN_HEAT_ON:  cfg_nxt.min_heater_on_ms  = cfg_if.data[TIME_W-1:0];
        REG_MIN_HEAT_OFF: cfg_nxt.min_heater_off_ms = cfg_if.data[TIME_W-1:0];
        REG_MIN_COOL_ON:  cfg_nxt.min_cooler_on_ms  = cfg_if.data[TIME_W-1:0];
        REG_MIN_COOL_OFF: cfg_nxt.min_cooler_off_ms = cfg_if.data[TIME_W-1:0];
        REG_ENABLE_MASK:  cfg_nxt.enable_mask       = cfg_if.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint          <= 12'sd288;
      cfg_r.hyst_below        <= 8'd8;
      cfg_r.hyst_above        <= 8'd8;
      cfg_r.min_heater_on_ms  <= '0;
      cfg_r.min_heater_off_ms <= '0;
      cfg_r.min_cooler_on_ms  <= '0;
      cfg_r.min_cooler_off_ms <= '0;
      cfg_r.enable_mask       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/thc_decide.sv]
`timescale 1ns / 1ps
// Mode decision for one sample: thresholds, lockout timers, next state.
// Depends on thc_pkg.
module thc_decide (
  input  thc_pkg::thc_cfg_t   cfg,
  input  thc_pkg::thc_state_t state,
  input  logic signed [11:0]  temp_sample,
  input  logic                sensor_lost,
  input  logic [31:0]         now_ms,
  output thc_pkg::thc_state_t state_nxt
);
  import thc_pkg::*;

  localparam int unsigned PROD_W = HYST_W + 9;

  logic signed [THRESH_W-1:0] tgt;
  logic signed [THRESH_W-1:0] temp;
  logic signed [THRESH_W-1:0] heater_on;
  logic signed [THRESH_W-1:0] cooler_on;
  logic signed [THRESH_W-1:0] heater_off;
  logic signed [THRESH_W-1:0] cooler_off;
  logic [PROD_W-1:0]          prod_low;
  logic [PROD_W-1:0]          prod_high;
  logic [TIME_W-1:0]          heat_elapsed;
  logic [TIME_W-1:0]          cool_elapsed;
  logic                       heat_en;
  logic                       cool_en;
  logic                       heat_start;
  logic                       cool_start;

  assign tgt  = THRESH_W'(cfg.setpoint);
  assign temp = THRESH_W'(temp_sample);
  assign heat_en = cfg.enable_mask[0];
  assign cool_en = cfg.enable_mask[1];

  assign prod_low  = PROD_W'(cfg.hyst_below) * PROD_W'(HYST_FACTOR_Q8);
  assign prod_high = PROD_W'(cfg.hyst_above) * PROD_W'(HYST_FACTOR_Q8);

  assign heater_on  = tgt - signed'(THRESH_W'(cfg.hyst_below));
  assign cooler_on  = tgt + signed'(THRESH_W'(cfg.hyst_above));
  assign heater_off = tgt - signed'(THRESH_W'(prod_low[PROD_W-1:8]));
  assign cooler_off = tgt + signed'(THRESH_W'(prod_high[PROD_W-1:8]));

  assign heat_elapsed = now_ms - state.heater_toggle_time;
  assign cool_elapsed = now_ms - state.cooler_toggle_time;

  assign heat_start = !sensor_lost && heat_en && (temp <= heater_on)
                      && (heat_elapsed >= cfg.min_heater_off_ms);
  assign cool_start = !sensor_lost && cool_en && (temp >= cooler_on)
                      && (cool_elapsed >= cfg.min_cooler_off_ms);

  always_comb begin
    state_nxt = state;
    case (state.mode)
      MODE_HEAT: begin
        if ((!heat_en || sensor_lost || temp >= heater_off)
            && heat_elapsed >= cfg.min_heater_on_ms) begin
          state_nxt.mode = MODE_IDLE;
          state_nxt.heater_toggle_time = now_ms;
        end
      end
      MODE_COOL: begin
        if ((!cool_en || sensor_lost || temp <= cooler_off)
            && cool_elapsed >= cfg.min_cooler_on_ms) begin
          state_nxt.mode = MODE_IDLE;
          state_nxt.cooler_toggle_time = now_ms;
        end
      end
      default: begin
        // idle; cooler check wins when both fire
        state_nxt.mode = MODE_IDLE;
        if (heat_start) begin
          state_nxt.mode = MODE_HEAT;
          state_nxt.heater_toggle_time = now_ms;
        end
        if (cool_start) begin
          state_nxt.mode = MODE_COOL;
          state_nxt.cooler_toggle_time = now_ms;
        end
      end
    endcase
  end

endmodule

[rtl/heat_cool_hysteresis_thermostat.sv]
`timescale 1ns / 1ps
// Heat/cool thermostat with hysteresis and minimum on/off lockout times.
// Depends on thc_pkg, thc_in_if, thc_out_if, thc_cfg_if, thc_cfg_regs, thc_decide.
//
// Takes one sample word per clock while the sink keeps up, and returns one
// result word per sample: the sample lands in an input register, and the
// mode decision and the mode/toggle-time update go from there into the
// result register. The state loop closes in that single
// decision stage, so back-to-back samples each see the state left by the
// one before. A waiting result holds the input register, so input stays
// open under a waiting result only while the input register is empty;
// once both hold a word, input stalls until the sink takes the result.
// Configuration writes are always taken and should be made while no
// sample is in flight.
module heat_cool_hysteresis_thermostat (
  input  logic      clk,
  input  logic      rst_n,
  thc_in_if.sink    in_if,
  thc_out_if.source out_if,
  thc_cfg_if.sink   cfg_if
);
  import thc_pkg::*;

  thc_cfg_t   cfg;
  thc_state_t state_r;
  thc_state_t state_nxt;

  logic                     s1_valid_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic                     s1_lost_r;
  logic [TIME_W-1:0]        s1_now_r;

  logic       out_valid_r;
  logic [1:0] out_mode_r;
  logic       out_heat_r;
  logic       out_cool_r;

  logic advance;
  logic in_fire;

  thc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  thc_decide u_decide (
    .cfg         (cfg),
    .state       (state_r),
    .temp_sample (s1_temp_r),
    .sensor_lost (s1_lost_r),
    .now_ms      (s1_now_r),
    .state_nxt   (state_nxt)
  );

  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  assign out_if.valid        = out_valid_r;
  assign out_if.mode         = out_mode_r;
  assign out_if.heater_drive = out_heat_r;
  assign out_if.cooler_drive = out_cool_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r.mode               <= MODE_IDLE;
      state_r.heater_toggle_time <= '0;
      state_r.cooler_toggle_time <= '0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_fire;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_temp_r <= in_if.temp_sample;
      s1_lost_r <= in_if.sensor_lost;
      s1_now_r  <= in_if.now_ms;
    end
    if (advance && s1_valid_r) begin
      out_mode_r <= state_nxt.mode;
      out_heat_r <= (state_nxt.mode == MODE_HEAT);
      out_cool_r <= (state_nxt.mode == MODE_COOL);
    end
  end

endmodule

[test/thermostat_checker.sv]
`timescale 1ns / 1ps
// Checker for heat_cool_hysteresis_thermostat: tracks register writes, predicts
// the mode and drive levels of every accepted sample and compares result words.
// Depends on thc_pkg, thc_in_if, thc_out_if, thc_cfg_if.
module thermostat_checker (
  input  logic clk,
  input  logic rst_n,
  thc_in_if    in_ch,
  thc_out_if   out_ch,
  thc_cfg_if   cfg_ch,
  output int   mismatches,
  output int   words_due
);
  import thc_pkg::*;

  typedef struct packed {
    mode_t mode;
    logic  heater;
    logic  cooler;
  } drive_word_t;

  logic signed [TEMP_W-1:0] set_target;
  logic [HYST_W-1:0]        set_hyst_lo;
  logic [HYST_W-1:0]        set_hyst_hi;
  logic [TIME_W-1:0]        set_heat_on_ms;
  logic [TIME_W-1:0]        set_heat_off_ms;
  logic [TIME_W-1:0]        set_cool_on_ms;
  logic [TIME_W-1:0]        set_cool_off_ms;
  logic [1:0]               set_enable;

  mode_t             cur_mode;
  logic [TIME_W-1:0] heat_flip_ms;
  logic [TIME_W-1:0] cool_flip_ms;

  drive_word_t drive_q[$];
  drive_word_t want;
  int          words_seen;

  task automatic report(string what, int got, int exp_val);
    $display("%0t word %0d: %s got %0d want %0d", $time, words_seen, what, got, exp_val);
    mismatches++;
  endtask

  function automatic drive_word_t thermostat_next(logic signed [TEMP_W-1:0] t, logic lost,
                                                 logic [TIME_W-1:0] now);
    int          temp, tg, heat_on, cool_on, heat_off, cool_off;
    logic [31:0] heat_gap, cool_gap;
    logic        heat_en, cool_en;
    drive_word_t w;
    temp     = int'(t);
    tg       = int'(set_target);
    heat_on  = tg - int'(set_hyst_lo);
    cool_on  = tg + int'(set_hyst_hi);
    heat_off = tg - int'((32'(set_hyst_lo) * HYST_FACTOR_Q8) >> 8);
    cool_off = tg + int'((32'(set_hyst_hi) * HYST_FACTOR_Q8) >> 8);
    heat_en  = set_enable[0];
    cool_en  = set_enable[1];
    heat_gap = now - heat_flip_ms;
    cool_gap = now - cool_flip_ms;
    case (cur_mode)
      MODE_HEAT: begin
        if ((!heat_en || lost || temp >= heat_off) && heat_gap >= set_heat_on_ms) begin
          heat_flip_ms = now;
          cur_mode     = MODE_IDLE;
        end
      end
      MODE_COOL: begin
        if ((!cool_en || lost || temp <= cool_off) && cool_gap >= set_cool_on_ms) begin
          cool_flip_ms = now;
          cur_mode     = MODE_IDLE;
        end
      end
      default: begin
        // heater check first, cooler may override on the same word
        cur_mode = MODE_IDLE;
        if (!lost) begin
          if (heat_en && temp <= heat_on && heat_gap >= set_heat_off_ms) begin
            heat_flip_ms = now;
            cur_mode     = MODE_HEAT;
          end
          if (cool_en && temp >= cool_on && cool_gap >= set_cool_off_ms) begin
            cool_flip_ms = now;
            cur_mode     = MODE_COOL;
          end
        end
      end
    endcase
    w.mode   = cur_mode;
    w.heater = (cur_mode == MODE_HEAT);
    w.cooler = (cur_mode == MODE_COOL);
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      set_target      = 12'sd288;
      set_hyst_lo     = 8'd8;
      set_hyst_hi     = 8'd8;
      set_heat_on_ms  = '0;
      set_heat_off_ms = '0;
      set_cool_on_ms  = '0;
      set_cool_off_ms = '0;
      set_enable      = 2'b00;
      cur_mode        = MODE_IDLE;
      heat_flip_ms    = '0;
      cool_flip_ms    = '0;
      words_seen      = 0;
      drive_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          report("unexpected word, mode", int'(out_ch.mode), -1);
        end else begin
          want = drive_q.pop_front();
          if (out_ch.mode !== want.mode)
            report("mode", int'(out_ch.mode), int'(want.mode));
          if (out_ch.heater_drive !== want.heater)
            report("heater_drive", int'(out_ch.heater_drive), int'(want.heater));
          if (out_ch.cooler_drive !== want.cooler)
            report("cooler_drive", int'(out_ch.cooler_drive), int'(want.cooler));
        end
        words_seen++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_SETPOINT:     set_target      = cfg_ch.data[TEMP_W-1:0];
          REG_HYST_LOW:     set_hyst_lo     = cfg_ch.data[HYST_W-1:0];
          REG_HYST_HIGH:    set_hyst_hi     = cfg_ch.data[HYST_W-1:0];
          REG_MIN_HEAT_ON:  set_heat_on_ms  = cfg_ch.data;
          REG_MIN_HEAT_OFF: set_heat_off_ms = cfg_ch.data;
          REG_MIN_COOL_ON:  set_cool_on_ms  = cfg_ch.data;
          REG_MIN_COOL_OFF: set_cool_off_ms = cfg_ch.data;
          REG_ENABLE_MASK:  set_enable      = cfg_ch.data[1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        drive_q.push_back(thermostat_next(in_ch.temp_sample, in_ch.sensor_lost, in_ch.now_ms));
    end
    words_due <= drive_q.size();
  end

endmodule

[test/tb_heat_cool_hysteresis_thermostat.sv]
`timescale 1ns / 1ps
// Top of the thermostat testbench: clock, reset, sample and register stimulus,
// random stalls on both channels and the final verdict.
// Depends on thc_pkg, the three channel interfaces, the DUT and thermostat_checker.
module tb_heat_cool_hysteresis_thermostat;
  import thc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_no = 0;
  int   mismatches;
  int   words_due;

  wire quiet = (cycle_no >= 600 && cycle_no < 900);

  thc_in_if  in_ch ();
  thc_out_if out_ch ();
  thc_cfg_if cfg_ch ();

  heat_cool_hysteresis_thermostat dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  thermostat_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    out_ch.ready <= quiet || ($urandom_range(99) >= 12);
  end

  task automatic send_sample(logic signed [TEMP_W-1:0] t, logic lost, logic [TIME_W-1:0] now);
    if (!quiet && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.temp_sample <= t;
    in_ch.sensor_lost <= lost;
    in_ch.now_ms      <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // register writes only once every pending word has come back
  task automatic cfg_put(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_lockout();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 32) return $urandom;
    return $urandom_range(0, 60);
  endfunction

  initial begin
    int                       tg, hl, hh, span, v, guard;
    int unsigned              r;
    logic [TIME_W-1:0]        clock_ms;
    logic signed [TEMP_W-1:0] t;
    logic                     lost;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.temp_sample <= '0;
    in_ch.sensor_lost <= 1'b0;
    in_ch.now_ms      <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_SETPOINT;
    cfg_ch.data       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both devices disabled after reset
    send_sample(12'sd250, 1'b0, 32'd5);
    cfg_put(REG_ENABLE_MASK, 32'd3);
    send_sample(12'sd280, 1'b0, 32'd10);   // exactly heater-on threshold
    send_sample(12'sd283, 1'b0, 32'd11);
    send_sample(12'sd284, 1'b0, 32'd12);   // heater-off threshold
    send_sample(12'sd296, 1'b0, 32'd13);   // cooler-on threshold
    send_sample(12'sd293, 1'b0, 32'd14);
    send_sample(12'sd292, 1'b0, 32'd15);   // cooler-off threshold
    send_sample(-12'sd2048, 1'b1, 32'd16); // lost sensor keeps idle
    send_sample(-12'sd2048, 1'b0, 32'd17);
    send_sample(12'sd0, 1'b1, 32'd18);     // lost sensor stops heating
    send_sample(12'sd2047, 1'b0, 32'd19);
    send_sample(12'sd0, 1'b1, 32'd20);     // lost sensor stops cooling
    send_sample(12'sd2047, 1'b0, 32'd21);
    cfg_put(REG_ENABLE_MASK, 32'd1);
    send_sample(12'sd2047, 1'b0, 32'd22);  // cooler disabled while cooling
    send_sample(-12'sd2048, 1'b0, 32'd23);
    cfg_put(REG_ENABLE_MASK, 32'd2);
    send_sample(-12'sd2048, 1'b0, 32'd24); // heater disabled while heating
    send_sample(-12'sd2048, 1'b0, 32'd25);
    // zero hysteresis: both checks fire on one word, cooler wins
    cfg_put(REG_ENABLE_MASK, 32'd3);
    cfg_put(REG_HYST_LOW, 32'd0);
    cfg_put(REG_HYST_HIGH, 32'd0);
    send_sample(12'sd288, 1'b0, 32'd26);
    // longest lockout passes only on a full wrap of the difference
    cfg_put(REG_MIN_COOL_ON, 32'hFFFF_FFFF);
    send_sample(12'sd0, 1'b0, 32'd27);
    send_sample(12'sd0, 1'b0, 32'd25);
    cfg_put(REG_MIN_HEAT_OFF, 32'd100);
    send_sample(12'sd0, 1'b0, 32'd125);
    send_sample(12'sd0, 1'b0, 32'd126);

    clock_ms = 32'd200;
    for (int ph = 0; ph < 8; ph++) begin
      tg = (ph == 1) ? -880 : (ph == 2) ? 2000 : int'($urandom_range(0, 2880)) - 880;
      hl = (ph == 1) ? 255 : (ph == 3) ? 0 : int'($urandom_range(0, 255));
      hh = (ph == 2) ? 255 : (ph == 3) ? 0 : int'($urandom_range(0, 255));
      if (ph == 0) begin
        tg = 288;
        hl = 8;
        hh = 8;
      end
      cfg_put(REG_SETPOINT, 32'(tg));
      cfg_put(REG_HYST_LOW, 32'(hl));
      cfg_put(REG_HYST_HIGH, 32'(hh));
      cfg_put(REG_MIN_HEAT_ON, (ph == 0) ? 32'd0 : pick_lockout());
      cfg_put(REG_MIN_HEAT_OFF, (ph == 0) ? 32'd0 : pick_lockout());
      cfg_put(REG_MIN_COOL_ON, (ph == 0) ? 32'd0 : pick_lockout());
      cfg_put(REG_MIN_COOL_OFF, (ph == 0) ? 32'd0 : pick_lockout());
      cfg_put(REG_ENABLE_MASK, (ph == 4) ? 32'd0 : (ph == 5) ? 32'd1 : (ph == 6) ? 32'd2 : 32'd3);
      span = ((hl > hh) ? hl : hh) + 24;
      repeat (81) begin
        if ($urandom_range(99) < 20) begin
          t = TEMP_W'($urandom);
        end else begin
          v = tg + int'($urandom_range(0, 2 * span)) - span;
          if (v > 2047) v = 2047;
          if (v < -2048) v = -2048;
          t = TEMP_W'(v);
        end
        lost = ($urandom_range(99) < 8);
        r = $urandom_range(99);
        if (r < 88)      clock_ms = clock_ms + $urandom_range(0, 40);
        else if (r < 94) clock_ms = $urandom;
        else if (r < 97) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
        else             clock_ms = clock_ms - $urandom_range(1, 5);
        send_sample(t, lost, clock_ms);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (words_due != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
